FILE: rtl/stl_pkg.sv
// shared constants and command/status types for the sorted threshold list
`default_nettype none
package stl_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned DefTagBits  = 16;

  localparam int unsigned ValW   = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned TotW   = 38;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned DivCntW = 7;

  localparam logic [2:0] MODE_READ    = 3'd0;
  localparam logic [2:0] MODE_INSERT  = 3'd1;
  localparam logic [2:0] MODE_DELETE  = 3'd2;
  localparam logic [2:0] MODE_ADVANCE = 3'd3;
  localparam logic [2:0] MODE_REWIND  = 3'd4;
  localparam logic [2:0] MODE_SHARE   = 3'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BELOW  = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_NOCUR  = 3'd3;
  localparam logic [2:0] ST_ZERO   = 3'd4;

  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic       wr_new;
    logic       set_status;
    logic [2:0] status;
    logic       occ_inc;
    logic       occ_dec;
    logic       cur_inc;
    logic       cur_clr;
    logic       cur_set;
    logic       tot_add;
    logic       mul;
    logic       div_start;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       below_thr;
    logic       full;
    logic       empty;
    logic       has_cur;
    logic       cur_last;
    logic       tot_zero;
    logic       rd_gt;
    logic       div_busy;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/sorted_threshold_list_share.sv
// top level: sorted threshold list with cursor, running total and share
// read, advance and rewind do no shift; insert shifts up to the whole list
// delete shifts the entries behind the cursor; share uses a 64-step divider
// the shift of insert and delete moves one entry per cycle through the memory, reading and writing in the same cycle
// one request at a time; the next is taken the cycle after the result is loaded
// reset clears the list, cursor, total and threshold; no clearing pass on the memory
`default_nettype none
module sorted_threshold_list_share import stl_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity,
  parameter int unsigned TAG_BITS = DefTagBits
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [2:0]      mode_i,
  input  wire logic [ValW-1:0] entry_value_i,
  input  wire logic [TagW-1:0] entry_tag_i,
  input  wire logic [ValW-1:0] amount_i,
  input  wire logic            cfg_we_i,
  input  wire logic [ValW-1:0] cfg_wdata_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [2:0]           status_o,
  output logic                 cursor_valid_o,
  output logic [ValW-1:0]      cursor_value_o,
  output logic [TagW-1:0]      cursor_tag_o,
  output logic                 at_end_o,
  output logic [ValW-1:0]      share_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  cmd_t            cmd;
  sts_t            sts;
  logic [CntW-1:0] occ, cur;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic            in_take;

  assign in_take = in_valid_i && !in_stall_o;

  stl_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sts_i(sts), .occ_i(occ), .cur_i(cur),
    .cmd_o(cmd), .rd_addr_o(rd_addr), .wr_addr_o(wr_addr)
  );

  stl_dp #(.CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS)) u_dp (
    .clk_i, .rst_ni, .in_take_i(in_take),
    .mode_i, .entry_value_i, .entry_tag_i, .amount_i,
    .cfg_we_i, .cfg_wdata_i,
    .cmd_i(cmd), .rd_addr_i(rd_addr), .wr_addr_i(wr_addr),
    .out_stall_i, .sts_o(sts), .occ_o(occ), .cur_o(cur),
    .out_valid_o, .status_o, .cursor_valid_o, .cursor_value_o,
    .cursor_tag_o, .at_end_o, .share_o
  );

endmodule
`default_nettype wire

FILE: rtl/stl_dp.sv
// datapath: entry memory, cursor, total, multiplier, divider and result register
`default_nettype none
module stl_dp import stl_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity,
  parameter int unsigned TAG_BITS = DefTagBits,
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_take_i,
  input  wire logic [2:0]      mode_i,
  input  wire logic [ValW-1:0] entry_value_i,
  input  wire logic [TagW-1:0] entry_tag_i,
  input  wire logic [ValW-1:0] amount_i,
  input  wire logic            cfg_we_i,
  input  wire logic [ValW-1:0] cfg_wdata_i,
  input  wire cmd_t            cmd_i,
  input  wire logic [IdxW-1:0] rd_addr_i,
  input  wire logic [IdxW-1:0] wr_addr_i,
  input  wire logic            out_stall_i,
  output sts_t                 sts_o,
  output logic [CntW-1:0]      occ_o,
  output logic [CntW-1:0]      cur_o,
  output logic                 out_valid_o,
  output logic [2:0]           status_o,
  output logic                 cursor_valid_o,
  output logic [ValW-1:0]      cursor_value_o,
  output logic [TagW-1:0]      cursor_tag_o,
  output logic                 at_end_o,
  output logic [ValW-1:0]      share_o
);

  logic [ValW-1:0]     mem_val [CAPACITY];
  logic [TAG_BITS-1:0] mem_tag [CAPACITY];

  logic [ValW-1:0]     rd_val_q;
  logic [TAG_BITS-1:0] rd_tag_q;
  logic [2:0]          mode_q;
  logic [ValW-1:0]     val_q, amt_q, thr_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [CntW-1:0]     occ_q, cur_q;
  logic [TotW-1:0]     tot_q;
  logic [2:0]          st_q;
  logic [ProdW-1:0]    prod_q, dq_q;
  logic [TotW-1:0]     rem_q;
  logic [DivCntW-1:0]  dcnt_q;
  logic                out_valid_q;

  logic [31:0]         tag_ext;
  logic [31:0]         rd_tag_ext;
  logic [TAG_BITS-1:0] wr_tag;
  logic [ValW-1:0]     wr_val;
  logic                has_cur;
  logic [TotW:0]       tot_sum;
  logic [TotW:0]       trial;
  logic                ge;
  logic [ValW-1:0]     share_sat;
  logic                out_free;

  assign tag_ext    = {{(32 - TagW){1'b0}}, entry_tag_i};
  assign rd_tag_ext = {{(32 - TAG_BITS){1'b0}}, rd_tag_q};
  assign wr_tag     = cmd_i.wr_new ? tag_q : rd_tag_q;
  assign wr_val     = cmd_i.wr_new ? val_q : rd_val_q;
  assign has_cur    = cur_q < occ_q;
  assign tot_sum    = {1'b0, tot_q} + {{(TotW + 1 - ValW){1'b0}}, val_q};
  assign trial      = {rem_q, dq_q[ProdW-1]};
  assign ge         = trial >= {1'b0, tot_q};
  assign share_sat  = (|dq_q[ProdW-1:ValW]) ? '1 : dq_q[ValW-1:0];
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_val[wr_addr_i] <= wr_val;
      mem_tag[wr_addr_i] <= wr_tag;
    end
    if (cmd_i.rd_en) begin
      rd_val_q <= mem_val[rd_addr_i];
      rd_tag_q <= mem_tag[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      mode_q <= mode_i;
      val_q  <= entry_value_i;
      tag_q  <= tag_ext[TAG_BITS-1:0];
      amt_q  <= amount_i;
    end
    if (cmd_i.mul) begin
      prod_q <= rd_val_q * amt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      occ_q       <= '0;
      cur_q       <= '0;
      tot_q       <= '0;
      st_q        <= ST_OK;
      dcnt_q      <= '0;
      dq_q        <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      status_o       <= ST_OK;
      cursor_valid_o <= 1'b0;
      cursor_value_o <= '0;
      cursor_tag_o   <= '0;
      at_end_o       <= 1'b1;
      share_o        <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (cmd_i.set_status) st_q <= cmd_i.status;
      if (cmd_i.occ_inc) occ_q <= occ_q + 1'b1;
      if (cmd_i.occ_dec) occ_q <= occ_q - 1'b1;
      if (cmd_i.cur_inc) cur_q <= cur_q + 1'b1;
      if (cmd_i.cur_clr) cur_q <= '0;
      if (cmd_i.cur_set) cur_q <= CntW'(wr_addr_i);
      if (cmd_i.tot_add) tot_q <= tot_sum[TotW] ? '1 : tot_sum[TotW-1:0];
      if (cmd_i.div_start) begin
        dq_q   <= prod_q;
        rem_q  <= '0;
        dcnt_q <= DivCntW'(ProdW);
      end else if (dcnt_q != '0) begin
        dq_q   <= {dq_q[ProdW-2:0], ge};
        rem_q  <= ge ? TotW'(trial - {1'b0, tot_q}) : trial[TotW-1:0];
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q    <= 1'b1;
        status_o       <= st_q;
        cursor_valid_o <= has_cur;
        cursor_value_o <= has_cur ? rd_val_q : '0;
        cursor_tag_o   <= has_cur ? rd_tag_ext[TagW-1:0] : '0;
        at_end_o       <= !has_cur;
        share_o        <= (mode_q == MODE_SHARE && st_q == ST_OK) ? share_sat : '0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.mode      = mode_q;
    sts_o.below_thr = val_q < thr_q;
    sts_o.full      = occ_q == CntW'(CAPACITY);
    sts_o.empty     = occ_q == '0;
    sts_o.has_cur   = has_cur;
    sts_o.cur_last  = ({1'b0, cur_q} + 1'b1) == {1'b0, occ_q};
    sts_o.tot_zero  = tot_q == '0;
    sts_o.rd_gt     = rd_val_q > val_q;
    sts_o.div_busy  = dcnt_q != '0;
    sts_o.out_free  = out_free;
  end

  assign occ_o       = occ_q;
  assign cur_o       = cur_q;
  assign out_valid_o = out_valid_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(CAPACITY)) else $error("occupancy above capacity");
  a_cur_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= occ_q) else $error("cursor beyond end of list");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dcnt_q != '0 && !cmd_i.div_start) |=> dcnt_q == $past(dcnt_q) - 1'b1)
    else $error("divider count did not step");

endmodule
`default_nettype wire

FILE: rtl/stl_ctrl.sv
// controller: sequences the scan, shift, fetch, multiply and divide steps
`default_nettype none
module stl_ctrl import stl_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity,
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire sts_t            sts_i,
  input  wire logic [CntW-1:0] occ_i,
  input  wire logic [CntW-1:0] cur_i,
  output cmd_t                 cmd_o,
  output logic [IdxW-1:0]      rd_addr_o,
  output logic [IdxW-1:0]      wr_addr_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_INS_SH = 4'd2;
  localparam logic [3:0] S_INS_WR = 4'd3;
  localparam logic [3:0] S_DEL_SH = 4'd4;
  localparam logic [3:0] S_FETCH  = 4'd5;
  localparam logic [3:0] S_FETCHW = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_DIVS   = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]      state_q, state_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            shr_q, shr_d;
  logic [CntW-1:0] occ_m1;
  logic [CntW:0]   j_p2;

  assign occ_m1     = occ_i - 1'b1;
  assign j_p2       = {{(CntW + 1 - IdxW){1'b0}}, j_q} + 2'd2;
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d   = state_q;
    j_d       = j_q;
    pos_d     = pos_q;
    shr_d     = shr_q;
    cmd_o     = '0;
    rd_addr_o = '0;
    wr_addr_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          shr_d   = 1'b0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.set_status = 1'b1;
        cmd_o.status     = ST_OK;
        state_d          = S_FETCH;
        unique case (sts_i.mode)
          MODE_INSERT: begin
            if (sts_i.below_thr) begin
              cmd_o.status = ST_BELOW;
            end else if (sts_i.full) begin
              cmd_o.status = ST_FULL;
            end else if (sts_i.empty) begin
              pos_d   = '0;
              state_d = S_INS_WR;
            end else begin
              cmd_o.rd_en = 1'b1;
              rd_addr_o   = occ_m1[IdxW-1:0];
              j_d         = occ_m1[IdxW-1:0];
              state_d     = S_INS_SH;
            end
          end
          MODE_DELETE: begin
            if (!sts_i.has_cur) begin
              cmd_o.status = ST_NOCUR;
            end else if (sts_i.cur_last) begin
              cmd_o.occ_dec = 1'b1;
            end else begin
              cmd_o.rd_en = 1'b1;
              rd_addr_o   = IdxW'(cur_i + 1'b1);
              j_d         = cur_i[IdxW-1:0];
              state_d     = S_DEL_SH;
            end
          end
          MODE_ADVANCE: begin
            if (sts_i.has_cur) cmd_o.cur_inc = 1'b1;
            else cmd_o.status = ST_NOCUR;
          end
          MODE_REWIND: begin
            cmd_o.cur_clr = 1'b1;
          end
          MODE_SHARE: begin
            if (!sts_i.has_cur) cmd_o.status = ST_NOCUR;
            else if (sts_i.tot_zero) cmd_o.status = ST_ZERO;
            else shr_d = 1'b1;
          end
          default: begin
            if (!sts_i.has_cur) cmd_o.status = ST_NOCUR;
          end
        endcase
      end
      S_INS_SH: begin
        if (sts_i.rd_gt) begin
          pos_d   = IdxW'(j_q + 1'b1);
          state_d = S_INS_WR;
        end else begin
          cmd_o.wr_en = 1'b1;
          wr_addr_o   = IdxW'(j_q + 1'b1);
          if (j_q == '0) begin
            pos_d   = '0;
            state_d = S_INS_WR;
          end else begin
            cmd_o.rd_en = 1'b1;
            rd_addr_o   = j_q - 1'b1;
            j_d         = j_q - 1'b1;
          end
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_new  = 1'b1;
        wr_addr_o     = pos_q;
        cmd_o.occ_inc = 1'b1;
        cmd_o.cur_set = 1'b1;
        cmd_o.tot_add = 1'b1;
        state_d       = S_FETCH;
      end
      S_DEL_SH: begin
        cmd_o.wr_en = 1'b1;
        wr_addr_o   = j_q;
        if (j_p2 == {1'b0, occ_i}) begin
          cmd_o.occ_dec = 1'b1;
          state_d       = S_FETCH;
        end else begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = j_p2[IdxW-1:0];
          j_d         = IdxW'(j_q + 1'b1);
        end
      end
      S_FETCH: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = cur_i[IdxW-1:0];
        state_d     = S_FETCHW;
      end
      S_FETCHW: begin
        state_d = shr_q ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (!sts_i.div_busy) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q     <= '0;
      pos_q   <= '0;
      shr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      pos_q   <= pos_d;
      shr_q   <= shr_d;
    end
  end

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> state_q == S_IDLE) else $error("result loaded outside done");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.occ_inc && cmd_o.occ_dec)) else $error("occupancy raised and lowered at once");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_busy) |=> state_q == S_DIV)
    else $error("left divide early");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// testbench for the sorted threshold list: random and directed requests checked against a predictor
`default_nettype none
module tb_top;
  import stl_pkg::*;

  localparam int unsigned Cap = 64;
  localparam int unsigned WatchLimit = 20000;
  localparam logic [37:0] TotalMax = {38{1'b1}};

  typedef struct packed {
    logic [2:0]  status;
    logic        cursor_valid;
    logic [31:0] cursor_value;
    logic [15:0] cursor_tag;
    logic        at_end;
    logic [31:0] share;
  } list_result_t;

  class list_scoreboard;
    logic [31:0] values[Cap];
    logic [15:0] tags[Cap];
    int unsigned occupancy;
    int unsigned cursor;
    logic [37:0] total;
    logic [31:0] threshold;
    list_result_t pending[$];
    int unsigned errors;

    function new();
      occupancy = 0;
      cursor = 0;
      total = '0;
      threshold = '0;
      errors = 0;
    endfunction

    function bit has_entry();
      return cursor < occupancy;
    endfunction

    function void note_request(logic [2:0] mode, logic [31:0] value, logic [15:0] tag,
                               logic [31:0] amount);
      list_result_t r;
      int unsigned pos;
      logic [63:0] prod;
      logic [63:0] quot;
      logic [38:0] sum;
      r = '0;
      case (mode)
        MODE_INSERT: begin
          if (value < threshold) r.status = ST_BELOW;
          else if (occupancy >= Cap) r.status = ST_FULL;
          else begin
            pos = 0;
            while (pos < occupancy && values[pos] > value) pos++;
            for (int i = occupancy; i > pos; i--) begin
              values[i] = values[i-1];
              tags[i] = tags[i-1];
            end
            values[pos] = value;
            tags[pos] = tag;
            occupancy++;
            cursor = pos;
            sum = {1'b0, total} + value;
            total = (sum > {1'b0, TotalMax}) ? TotalMax : sum[37:0];
          end
        end
        MODE_DELETE: begin
          if (!has_entry()) r.status = ST_NOCUR;
          else begin
            for (int i = cursor; i + 1 < occupancy; i++) begin
              values[i] = values[i+1];
              tags[i] = tags[i+1];
            end
            occupancy--;
          end
        end
        MODE_ADVANCE: begin
          if (has_entry()) cursor++;
          else r.status = ST_NOCUR;
        end
        MODE_REWIND: cursor = 0;
        MODE_SHARE: begin
          if (!has_entry()) r.status = ST_NOCUR;
          else if (total == 0) r.status = ST_ZERO;
          else begin
            prod = 64'(values[cursor]) * 64'(amount);
            quot = prod / 64'(total);
            r.share = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
          end
        end
        default: if (!has_entry()) r.status = ST_NOCUR;
      endcase
      r.cursor_valid = has_entry();
      r.at_end = !has_entry();
      if (has_entry()) begin
        r.cursor_value = values[cursor];
        r.cursor_tag = tags[cursor];
      end
      pending.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp;
      if (pending.size() == 0) begin
        $error("result with no request waiting");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status exp %0d got %0d", exp.status, got.status); errors++;
      end
      if (got.cursor_valid !== exp.cursor_valid) begin
        $error("cursor_valid exp %0d got %0d", exp.cursor_valid, got.cursor_valid); errors++;
      end
      if (got.cursor_value !== exp.cursor_value) begin
        $error("cursor_value exp %0h got %0h", exp.cursor_value, got.cursor_value); errors++;
      end
      if (got.cursor_tag !== exp.cursor_tag) begin
        $error("cursor_tag exp %0h got %0h", exp.cursor_tag, got.cursor_tag); errors++;
      end
      if (got.at_end !== exp.at_end) begin
        $error("at_end exp %0d got %0d", exp.at_end, got.at_end); errors++;
      end
      if (got.share !== exp.share) begin
        $error("share exp %0h got %0h", exp.share, got.share); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] mode_i = MODE_READ;
  logic [31:0] entry_value_i = '0;
  logic [15:0] entry_tag_i = '0;
  logic [31:0] amount_i = '0;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic cursor_valid_o;
  logic [31:0] cursor_value_o;
  logic [15:0] cursor_tag_o;
  logic at_end_o;
  logic [31:0] share_o;

  list_scoreboard board = new();
  int unsigned idle_pct = 29;
  bit hold_off = 1'b0;
  int unsigned quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sorted_threshold_list_share dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .entry_value_i, .entry_tag_i,
    .amount_i, .cfg_we_i, .cfg_wdata_i, .out_valid_o, .out_stall_i, .status_o,
    .cursor_valid_o, .cursor_value_o, .cursor_tag_o, .at_end_o, .share_o
  );

  // result side: random stall, check on acceptance
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result({status_o, cursor_valid_o, cursor_value_o, cursor_tag_o,
                          at_end_o, share_o});
    out_stall_i <= hold_off || ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // valid stays high after acceptance; drain, or an idle gap in the next send, takes it down
  task automatic send(logic [2:0] mode, logic [31:0] value, logic [15:0] tag,
                      logic [31:0] amount);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    entry_value_i <= value;
    entry_tag_i <= tag;
    amount_i <= amount;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(mode, value, tag, amount);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [31:0] thr);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.threshold = thr;
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [31:0] v;
    pick = $urandom_range(99);
    v = ($urandom_range(3) == 0) ? 32'($urandom_range(7)) << 16 : $urandom;
    if (pick < 40) send(MODE_INSERT, v, 16'($urandom), $urandom);
    else if (pick < 55) send(MODE_DELETE, $urandom, 16'($urandom), $urandom);
    else if (pick < 70) send(MODE_ADVANCE, $urandom, 16'($urandom), $urandom);
    else if (pick < 76) send(MODE_REWIND, $urandom, 16'($urandom), $urandom);
    else if (pick < 90) send(MODE_SHARE, $urandom, 16'($urandom), $urandom);
    else send(3'($urandom_range(7)), $urandom, 16'($urandom), $urandom);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, extremes, equal values, zero total
    send(MODE_READ, '0, '0, '0);
    send(MODE_DELETE, '0, '0, '0);
    send(MODE_ADVANCE, '0, '0, '0);
    send(MODE_SHARE, '0, '0, 32'hFFFF_FFFF);
    send(MODE_INSERT, 32'h0, 16'h1234, '0);
    send(MODE_SHARE, '0, '0, 32'hFFFF_FFFF);
    send(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF, '0);
    send(MODE_INSERT, 32'h0001_0000, 16'h0001, '0);
    send(MODE_INSERT, 32'h0001_0000, 16'h0002, '0);
    send(MODE_SHARE, '0, '0, 32'hFFFF_FFFF);
    send(MODE_REWIND, '0, '0, '0);
    send(MODE_SHARE, '0, '0, 32'hFFFF_FFFF);
    send(3'd6, '0, '0, '0);
    send(3'd7, '0, '0, '0);
    repeat (5) send(MODE_ADVANCE, '0, '0, '0);
    send(MODE_REWIND, '0, '0, '0);
    send(MODE_DELETE, '0, '0, '0);
    set_threshold(32'hFFFF_FFFF);
    send(MODE_INSERT, 32'hFFFF_FFFE, 16'h5555, '0);
    send(MODE_INSERT, 32'hFFFF_FFFF, 16'hAAAA, 32'h1);
    set_threshold(32'h0);

    // fill to capacity with large values to hit full
    for (int i = 0; i < 70; i++) send(MODE_INSERT, 32'hF000_0000 | $urandom, 16'($urandom), '0);
    send(MODE_SHARE, '0, '0, 32'hFFFF_FFFF);
    repeat (70) send(MODE_DELETE, '0, '0, '0);
    send(MODE_REWIND, '0, '0, '0);
    repeat (70) send(MODE_DELETE, '0, '0, '0);

    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    repeat (20) send_random();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_threshold(32'h0002_0000);
        1: set_threshold($urandom);
        2: set_threshold(32'h0);
        default: set_threshold(32'h0000_8000);
      endcase
      idle_pct = (ph == 1) ? 0 : 29;
      for (int i = 0; i < 225; i++) send_random();
    end
    idle_pct = 29;

    drain();
    if (board.errors == 0 && board.pending.size() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
rtl/stl_pkg.sv
rtl/stl_dp.sv
rtl/stl_ctrl.sv
rtl/sorted_threshold_list_share.sv
bench/tb_top.sv
